### rtl/core/ppl_pkg.sv
`timescale 1ns / 1ps

package ppl_pkg;

   localparam int SHININESS = 40;

   localparam int UNI_SQRT_STAGES = 32;
   localparam int UNI_DIV_STAGES = 31;
   localparam int UNI_LAT = 5 + UNI_SQRT_STAGES + UNI_DIV_STAGES + 1;
   localparam int DOT_LAT = 3;

   typedef logic signed [34:0] raw_type;
   typedef logic signed [31:0] unit_type;
   typedef logic [30:0] frac_type;

   typedef enum logic [2:0] {
      CSR_LIGHT_X  = 3'd0,
      CSR_LIGHT_Y  = 3'd1,
      CSR_LIGHT_Z  = 3'd2,
      CSR_CAMERA_X = 3'd3,
      CSR_CAMERA_Y = 3'd4,
      CSR_CAMERA_Z = 3'd5
   } csr_index_type;

endpackage

### rtl/core/ppl_unitize.sv
`timescale 1ns / 1ps

module ppl_unitize
   import ppl_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  raw_type  vec_in [3],
   output unit_type vec_out [3]
);

   localparam int SQN = UNI_SQRT_STAGES;
   localparam int DVN = UNI_DIV_STAGES;

   logic [33:0] mag1_ff [3];
   logic [2:0]  neg1_ff;

   logic [33:0] mag2_ff [3];
   logic [2:0]  neg2_ff;
   logic [5:0]  pos2_ff;
   logic        zero2_ff;

   logic [30:0] mag3_ff [3];
   logic [2:0]  neg3_ff;
   logic        zero3_ff;

   logic [61:0] sq4_ff [3];
   logic [30:0] mag4_ff [3];
   logic [2:0]  neg4_ff;
   logic        zero4_ff;

   logic [63:0] sum5_ff;
   logic [30:0] mag5_ff [3];
   logic [2:0]  neg5_ff;
   logic        zero5_ff;

   logic [63:0] sq_rad_ff  [SQN];
   logic [33:0] sq_rem_ff  [SQN];
   logic [31:0] sq_root_ff [SQN];
   logic [30:0] sq_mag_ff  [SQN][3];
   logic [2:0]  sq_neg_ff  [SQN];
   logic        sq_zero_ff [SQN];

   logic [63:0] sq_rad_in  [SQN];
   logic [33:0] sq_rem_in  [SQN];
   logic [31:0] sq_root_in [SQN];

   logic [31:0] dv_rem_ff  [DVN][3];
   logic [30:0] dv_quo_ff  [DVN][3];
   logic [31:0] dv_len_ff  [DVN];
   logic [2:0]  dv_neg_ff  [DVN];
   logic        dv_zero_ff [DVN];

   logic [31:0] dv_rem_in  [DVN][3];
   logic [30:0] dv_quo_in  [DVN][3];

   logic [33:0] or_w;
   logic [5:0]  pos_w;
   unit_type    out_ff [3];

   always_comb begin
      or_w = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      pos_w = '0;
      for (int b = 0; b < 34; b++) begin
         if (or_w[b]) begin
            pos_w = 6'(b);
         end
      end
   end

   always_comb begin
      logic [63:0] prad;
      logic [33:0] prem;
      logic [31:0] proot;
      logic [33:0] rem2;
      logic [33:0] trial;
      for (int k = 0; k < SQN; k++) begin
         if (k == 0) begin
            prad = sum5_ff;
            prem = '0;
            proot = '0;
         end else begin
            prad = sq_rad_ff[k-1];
            prem = sq_rem_ff[k-1];
            proot = sq_root_ff[k-1];
         end
         rem2 = {prem[31:0], prad[63:62]};
         trial = {proot, 2'b01};
         sq_rad_in[k] = {prad[61:0], 2'b00};
         if (rem2 >= trial) begin
            sq_rem_in[k] = rem2 - trial;
            sq_root_in[k] = {proot[30:0], 1'b1};
         end else begin
            sq_rem_in[k] = rem2;
            sq_root_in[k] = {proot[30:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic [31:0] prem;
      logic [30:0] pquo;
      logic [31:0] len;
      logic        bitv;
      logic [32:0] t;
      for (int k = 0; k < DVN; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               prem = {2'b00, sq_mag_ff[SQN-1][i][30:1]};
               pquo = '0;
               len = sq_root_ff[SQN-1];
               bitv = sq_mag_ff[SQN-1][i][0];
            end else begin
               prem = dv_rem_ff[k-1][i];
               pquo = dv_quo_ff[k-1][i];
               len = dv_len_ff[k-1];
               bitv = 1'b0;
            end
            t = {prem, bitv};
            if (t >= {1'b0, len}) begin
               dv_rem_in[k][i] = 32'(t - {1'b0, len});
               dv_quo_in[k][i] = {pquo[29:0], 1'b1};
            end else begin
               dv_rem_in[k][i] = t[31:0];
               dv_quo_in[k][i] = {pquo[29:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= vec_in[i][34];
            mag1_ff[i] <= vec_in[i][34] ? 34'(-vec_in[i]) : 34'(vec_in[i]);

            mag2_ff[i] <= mag1_ff[i];

            if (pos2_ff > 6'd30) begin
               mag3_ff[i] <= 31'(mag2_ff[i] >> (pos2_ff - 6'd30));
            end else begin
               mag3_ff[i] <= 31'(mag2_ff[i] << (6'd30 - pos2_ff));
            end

            sq4_ff[i] <= 62'(mag3_ff[i]) * 62'(mag3_ff[i]);
            mag4_ff[i] <= mag3_ff[i];
            mag5_ff[i] <= mag4_ff[i];
         end
         neg2_ff <= neg1_ff;
         pos2_ff <= pos_w;
         zero2_ff <= (or_w == '0);
         neg3_ff <= neg2_ff;
         zero3_ff <= zero2_ff;
         neg4_ff <= neg3_ff;
         zero4_ff <= zero3_ff;
         sum5_ff <= 64'(sq4_ff[0]) + 64'(sq4_ff[1]) + 64'(sq4_ff[2]);
         neg5_ff <= neg4_ff;
         zero5_ff <= zero4_ff;

         for (int k = 0; k < SQN; k++) begin
            sq_rad_ff[k] <= sq_rad_in[k];
            sq_rem_ff[k] <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            if (k == 0) begin
               sq_mag_ff[k] <= mag5_ff;
               sq_neg_ff[k] <= neg5_ff;
               sq_zero_ff[k] <= zero5_ff;
            end else begin
               sq_mag_ff[k] <= sq_mag_ff[k-1];
               sq_neg_ff[k] <= sq_neg_ff[k-1];
               sq_zero_ff[k] <= sq_zero_ff[k-1];
            end
         end

         for (int k = 0; k < DVN; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_quo_ff[k] <= dv_quo_in[k];
            if (k == 0) begin
               dv_len_ff[k] <= sq_root_ff[SQN-1];
               dv_neg_ff[k] <= sq_neg_ff[SQN-1];
               dv_zero_ff[k] <= sq_zero_ff[SQN-1];
            end else begin
               dv_len_ff[k] <= dv_len_ff[k-1];
               dv_neg_ff[k] <= dv_neg_ff[k-1];
               dv_zero_ff[k] <= dv_zero_ff[k-1];
            end
         end

         for (int i = 0; i < 3; i++) begin
            if (dv_zero_ff[DVN-1]) begin
               out_ff[i] <= '0;
            end else if (dv_neg_ff[DVN-1][i]) begin
               out_ff[i] <= -$signed({1'b0, dv_quo_ff[DVN-1][i]});
            end else begin
               out_ff[i] <= $signed({1'b0, dv_quo_ff[DVN-1][i]});
            end
         end
      end
   end

   assign vec_out = out_ff;

endmodule

### rtl/core/ppl_dot.sv
`timescale 1ns / 1ps

module ppl_dot
   import ppl_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  unit_type vec_a [3],
   input  unit_type vec_b [3],
   output frac_type dot_out
);

   logic signed [63:0] prod_ff [3];
   logic signed [63:0] sum_ff;
   frac_type           res_ff;
   logic [33:0]        shr_w;

   assign shr_w = 34'(sum_ff >>> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= 64'(vec_a[i]) * 64'(vec_b[i]);
         end
         sum_ff <= prod_ff[0] + prod_ff[1] + prod_ff[2];
         if (sum_ff <= 64'sd0) begin
            res_ff <= '0;
         end else if (shr_w > 34'(31'h4000_0000)) begin
            res_ff <= 31'h4000_0000;
         end else begin
            res_ff <= shr_w[30:0];
         end
      end
   end

   assign dot_out = res_ff;

endmodule

### rtl/core/phong_pixel_lighting.sv
`timescale 1ns / 1ps

// Per-fragment Phong lighting with white specular and green diffuse, no ambient term.
// Write the light and camera positions on the csr port while the block is idle. One
// fragment is taken per clock while the result side does not stall, and each result
// passes through two normalization passes in series (each a 32-stage square root
// and a 31-stage divider), two dot products and a 40-stage chain of multipliers for
// the specular power. A stall on the result side holds the whole pipeline.

module phong_pixel_lighting
   import ppl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // frag_pos_x, frag_pos_y, frag_pos_z, normal_x, normal_y, normal_z
   input  logic [191:0] req_tdata,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // color_red, color_green, color_blue
   output logic [47:0]  rsp_tdata,

   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int LAT = 1 + UNI_LAT + DOT_LAT + 2 + UNI_LAT + DOT_LAT + SHININESS + 1;
   localparam int LU_DL = DOT_LAT + 1;
   localparam int NU_DL = DOT_LAT;
   localparam int VU_DL = DOT_LAT + 2 + UNI_LAT;
   localparam int D_DL = 2 + UNI_LAT + DOT_LAT + SHININESS;

   logic signed [31:0] light_ff [3];
   logic signed [31:0] camera_ff [3];

   logic [LAT-1:0] vld_ff;
   logic           en;

   raw_type  lv_ff [3];
   raw_type  vv_ff [3];
   raw_type  nv_ff [3];
   raw_type  rv_ff [3];
   unit_type lu_w [3];
   unit_type vu_w [3];
   unit_type nu_w [3];
   unit_type ru_w [3];

   unit_type lu_dl_ff [LU_DL][3];
   unit_type nu_dl_ff [NU_DL][3];
   unit_type vu_dl_ff [VU_DL][3];
   logic [15:0] d15_dl_ff [D_DL];

   frac_type d_w;
   frac_type s_w;

   logic signed [63:0] rp_ff [3];
   frac_type pw_ff [SHININESS];
   frac_type pw_s_ff [SHININESS];

   logic [15:0] red_ff;
   logic [15:0] green_ff;

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata = {red_ff, green_ff, red_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            light_ff[i] <= '0;
            camera_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIGHT_X:  light_ff[0] <= csr_wdata;
            CSR_LIGHT_Y:  light_ff[1] <= csr_wdata;
            CSR_LIGHT_Z:  light_ff[2] <= csr_wdata;
            CSR_CAMERA_X: camera_ff[0] <= csr_wdata;
            CSR_CAMERA_Y: camera_ff[1] <= csr_wdata;
            CSR_CAMERA_Z: camera_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      logic signed [31:0] frag;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            frag = $signed(req_tdata[32*i +: 32]);
            lv_ff[i] <= 35'(light_ff[i]) - 35'(frag);
            vv_ff[i] <= 35'(camera_ff[i]) - 35'(frag);
            nv_ff[i] <= 35'($signed(req_tdata[32*(i+3) +: 32]));
         end
      end
   end

   ppl_unitize u_unit_l (.clock(clock), .en(en), .vec_in(lv_ff), .vec_out(lu_w));
   ppl_unitize u_unit_v (.clock(clock), .en(en), .vec_in(vv_ff), .vec_out(vu_w));
   ppl_unitize u_unit_n (.clock(clock), .en(en), .vec_in(nv_ff), .vec_out(nu_w));

   ppl_dot u_dot_nl (.clock(clock), .en(en), .vec_a(nu_w), .vec_b(lu_w), .dot_out(d_w));

   always_ff @(posedge clock) begin
      logic signed [63:0] t;
      if (en) begin
         lu_dl_ff[0] <= lu_w;
         nu_dl_ff[0] <= nu_w;
         vu_dl_ff[0] <= vu_w;
         for (int k = 1; k < LU_DL; k++) begin
            lu_dl_ff[k] <= lu_dl_ff[k-1];
         end
         for (int k = 1; k < NU_DL; k++) begin
            nu_dl_ff[k] <= nu_dl_ff[k-1];
         end
         for (int k = 1; k < VU_DL; k++) begin
            vu_dl_ff[k] <= vu_dl_ff[k-1];
         end
         d15_dl_ff[0] <= 16'(d_w >> 15);
         for (int k = 1; k < D_DL; k++) begin
            d15_dl_ff[k] <= d15_dl_ff[k-1];
         end

         for (int i = 0; i < 3; i++) begin
            rp_ff[i] <= $signed({33'd0, d_w}) * 64'(nu_dl_ff[NU_DL-1][i]);
            t = rp_ff[i] + (rp_ff[i] < 0 ? 64'sd536870911 : 64'sd0);
            rv_ff[i] <= 35'(t >>> 29) - 35'(lu_dl_ff[LU_DL-1][i]);
         end
      end
   end

   ppl_unitize u_unit_r (.clock(clock), .en(en), .vec_in(rv_ff), .vec_out(ru_w));

   ppl_dot u_dot_vr (
      .clock(clock), .en(en), .vec_a(vu_dl_ff[VU_DL-1]), .vec_b(ru_w), .dot_out(s_w)
   );

   always_ff @(posedge clock) begin
      logic [61:0] prod;
      if (en) begin
         for (int k = 0; k < SHININESS; k++) begin
            if (k == 0) begin
               prod = 62'(31'h4000_0000) * 62'(s_w);
               pw_s_ff[k] <= s_w;
            end else begin
               prod = 62'(pw_ff[k-1]) * 62'(pw_s_ff[k-1]);
               pw_s_ff[k] <= pw_s_ff[k-1];
            end
            pw_ff[k] <= 31'(prod >> 30);
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [15:0] spec;
      logic [16:0] g;
      if (en) begin
         spec = 16'(pw_ff[SHININESS-1] >> 15);
         g = 17'(d15_dl_ff[D_DL-1]) + 17'(spec);
         red_ff <= spec;
         green_ff <= (g > 17'd32768) ? 16'd32768 : g[15:0];
      end
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import ppl_pkg::*;
();

   typedef enum logic [1:0] {OP_FRAG, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type  kind;
      logic [2:0]   idx;
      logic [31:0]  val;
      logic [191:0] data;
   } stim_op_type;

   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;
   localparam longint UNIT_ONE = longint'(1) << 30;
   localparam logic [63:0] Q15_ONE = 64'd32768;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [47:0]  rsp_tdata;
   logic         csr_we = 0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   stim_op_type  pending_ops[$];
   logic [47:0]  color_queue[$];
   logic [31:0]  light_cam[6];
   int           sent_count = 0;
   int           total_frags = 0;
   int           error_count = 0;
   int           quiet_cycles = 0;

   phong_pixel_lighting dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void unit_vec(input longint v[3], output longint u[3]);
      logic [63:0] mag[3];
      logic [63:0] m, sum, len, q;
      bit neg[3];
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return;
      end
      while (m >= (64'd1 << 31)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 30)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] << 30) / len;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic longint clamped_dot(input longint a[3], input longint b[3]);
      longint s, r;
      s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      if (s <= 0) return 0;
      r = s >>> 30;
      return (r > UNIT_ONE) ? UNIT_ONE : r;
   endfunction

   function automatic logic [47:0] shade_fragment(input logic [191:0] d);
      longint lv[3], vv[3], nv[3], rv[3];
      longint lu[3], vu[3], nu[3], ru[3];
      longint f, dif, s;
      logic [63:0] p, diff15, spec15, g;
      for (int i = 0; i < 3; i++) begin
         f = longint'($signed(d[32*i +: 32]));
         lv[i] = longint'($signed(light_cam[i])) - f;
         vv[i] = longint'($signed(light_cam[3 + i])) - f;
         nv[i] = longint'($signed(d[32*(3 + i) +: 32]));
      end
      unit_vec(lv, lu);
      unit_vec(vv, vu);
      unit_vec(nv, nu);
      dif = clamped_dot(nu, lu);
      for (int i = 0; i < 3; i++) rv[i] = (dif * nu[i]) / (longint'(1) << 29) - lu[i];
      unit_vec(rv, ru);
      s = clamped_dot(vu, ru);
      p = 64'(UNIT_ONE);
      for (int i = 0; i < SHININESS; i++) p = (p * 64'(s)) >> 30;
      diff15 = 64'(dif) >> 15;
      spec15 = p >> 15;
      g = diff15 + spec15;
      if (g > Q15_ONE) g = Q15_ONE;
      if (spec15 > Q15_ONE) spec15 = Q15_ONE;
      return {spec15[15:0], g[15:0], spec15[15:0]};
   endfunction

   function automatic bit sender_idles();
      if (sent_count < total_frags / 3) return $urandom_range(99) < 31;
      if (sent_count < 2 * total_frags / 3) return $urandom_range(99) < 71;
      return 0;
   endfunction

   function automatic bit receiver_idles();
      if (sent_count < total_frags / 3) return $urandom_range(99) < 71;
      if (sent_count < 2 * total_frags / 3) return $urandom_range(99) < 31;
      return 0;
   endfunction

   always @(posedge clock) begin
      logic         nvalid;
      logic [191:0] ndata;
      logic         nwe;
      logic [2:0]   nidx;
      logic [31:0]  nval;
      stim_op_type  op;
      nvalid = req_tvalid;
      ndata = req_tdata;
      nwe = 0;
      nidx = csr_index;
      nval = csr_wdata;
      if (reset) begin
         nvalid = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            color_queue.push_back(shade_fragment(req_tdata));
            sent_count++;
         end
         quiet_cycles = (color_queue.size() == 0 && !req_tvalid) ? quiet_cycles + 1 : 0;
         if (!req_tvalid || req_tready) begin
            nvalid = 0;
            if (pending_ops.size() > 0) begin
               op = pending_ops[0];
               case (op.kind)
                  OP_FRAG: begin
                     if (!sender_idles()) begin
                        nvalid = 1;
                        ndata = op.data;
                        void'(pending_ops.pop_front());
                     end
                  end
                  OP_CSR: begin
                     if (quiet_cycles >= 8) begin
                        nwe = 1;
                        nidx = op.idx;
                        nval = op.val;
                        if (op.idx < 6) light_cam[op.idx] = op.val;
                        void'(pending_ops.pop_front());
                     end
                  end
                  default: begin
                     if (quiet_cycles >= 2) void'(pending_ops.pop_front());
                  end
               endcase
            end
         end
      end
      req_tvalid <= nvalid;
      req_tdata <= ndata;
      csr_we <= nwe;
      csr_index <= nidx;
      csr_wdata <= nval;
   end

   always @(posedge clock) begin
      logic [47:0] want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (color_queue.size() == 0) begin
               $error("unexpected transfer on result side: %h", rsp_tdata);
               error_count++;
            end else begin
               want = color_queue.pop_front();
               if (rsp_tdata[15:0] !== want[15:0]) begin
                  $error("color_red expected %0d actual %0d", want[15:0], rsp_tdata[15:0]);
                  error_count++;
               end
               if (rsp_tdata[31:16] !== want[31:16]) begin
                  $error("color_green expected %0d actual %0d", want[31:16],
                         rsp_tdata[31:16]);
                  error_count++;
               end
               if (rsp_tdata[47:32] !== want[47:32]) begin
                  $error("color_blue expected %0d actual %0d", want[47:32],
                         rsp_tdata[47:32]);
                  error_count++;
               end
            end
         end
         rsp_tready <= !receiver_idles();
      end
   end

   task automatic add_frag(input logic [31:0] px, py, pz, nx, ny, nz);
      stim_op_type op;
      op.kind = OP_FRAG;
      op.idx = '0;
      op.val = '0;
      op.data = {nz, ny, nx, pz, py, px};
      pending_ops.push_back(op);
      total_frags++;
   endtask

   task automatic add_csr(input logic [2:0] idx, input logic [31:0] val);
      stim_op_type op;
      op.kind = OP_CSR;
      op.idx = idx;
      op.val = val;
      op.data = '0;
      pending_ops.push_back(op);
   endtask

   task automatic add_setup(input logic [31:0] lx, ly, lz, cx, cy, cz);
      add_csr(CSR_LIGHT_X, lx);
      add_csr(CSR_LIGHT_Y, ly);
      add_csr(CSR_LIGHT_Z, lz);
      add_csr(CSR_CAMERA_X, cx);
      add_csr(CSR_CAMERA_Y, cy);
      add_csr(CSR_CAMERA_Z, cz);
   endtask

   initial begin
      stim_op_type drain;
      logic [31:0] h, r;
      for (int i = 0; i < 6; i++) light_cam[i] = '0;
      drain.kind = OP_DRAIN;
      drain.idx = '0;
      drain.val = '0;
      drain.data = '0;

      // Reset values first: everything at the origin, so L and V are minus the fragment.
      add_frag(0, 0, 0, 0, 0, 0);
      add_frag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h80000000);
      add_frag(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff);
      add_frag(32'h00010000, 0, 0, 32'hffff0000, 0, 0);
      // Light and camera at the extremes.
      add_setup(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                32'h80000000);
      add_frag(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff);
      add_frag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 0, 0);
      add_frag(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000);
      add_frag(0, 0, 0, 32'h00000001, 32'h00000001, 32'h00000001);
      // Light and camera at the same point straight above the origin: green overflow at the origin,
      // a fragment at the light and camera, zero normal.
      add_setup(0, 32'h000a0000, 0, 0, 32'h000a0000, 0);
      add_frag(0, 0, 0, 0, 32'h00010000, 0);
      add_frag(0, 0, 0, 0, 32'h7fffffff, 0);
      add_frag(0, 32'h000a0000, 0, 0, 32'h00010000, 0);
      add_frag(0, 0, 0, 0, 0, 0);
      add_frag(32'h00001000, 0, 32'hfffff000, 32'h00000100, 32'h00010000, 0);
      add_frag(0, 0, 0, 0, 32'hffff0000, 0);
      add_csr(CSR_SPARE_6, 32'hdeadbeef);
      add_csr(CSR_SPARE_7, 32'h12345678);
      add_frag(0, 0, 0, 0, 32'h00010000, 0);
      add_frag(32'h00002000, 0, 0, 0, 32'h00008000, 0);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 2 == 0) begin
            h = 32'h00010000 + $urandom_range(32'h00ff0000);
            add_setup(0, h, 0, 0, h, 0);
         end else begin
            add_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
         if (ph == 3) pending_ops.push_back(drain);
         for (int k = 0; k < 72; k++) begin
            if (ph % 2 == 0 && k % 4 != 0) begin
               r = h >> ($urandom_range(10) + 3);
               add_frag($urandom_range(r) - (r >> 1), $urandom_range(r >> 2),
                        $urandom_range(r) - (r >> 1), $urandom_range(32'h800) - 32'h400,
                        32'h00010000 + $urandom_range(32'h000f0000),
                        $urandom_range(32'h800) - 32'h400);
            end else begin
               add_frag($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
         end
      end
      add_setup(0, 0, 0, 0, 0, 0);
      add_frag($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      add_frag(0, 0, 0, 0, 0, 32'h00010000);

      repeat (6) @(posedge clock);
      reset <= 0;
      wait (pending_ops.size() == 0 && !req_tvalid && color_queue.size() == 0);
      repeat (250) @(posedge clock);
      if (error_count == 0 && color_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
